[hdl/iirl_pkg.sv]
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and constants of the indexed insert/remove list
// Capacity, entry width, operation and status codes, and the command that
// the control logic broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
`default_nettype none

package iirl_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;

	// Widths fixed by the interface.
	localparam int OP_W    = 3;
	localparam int POS_W   = 7;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Internal count and compare widths.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT      = 3'd0,
		OP_APPEND      = 3'd1,
		OP_REMOVE      = 3'd2,
		OP_REMOVE_LAST = 3'd3,
		OP_READ        = 3'd4,
		OP_WRITE       = 3'd5
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [CMP_W-1:0]       pos;
		logic [VALUE_BITS-1:0]  value;
	} cell_cmd_t;

	// Keeps the low VALUE_BITS bits of an interface word.
	function automatic logic [VALUE_BITS-1:0] to_entry(input logic [DATA_W-1:0] w);
		logic [63:0] wide;
		wide = 64'(w);
		return wide[VALUE_BITS-1:0];
	endfunction

	// Returns the low bits of an entry as an interface word.
	function automatic logic [DATA_W-1:0] from_entry(input logic [VALUE_BITS-1:0] e);
		logic [63:0] wide;
		wide = 64'(e);
		return wide[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/iirl_cell.sv]
// ----------------------------------------------------------------------------
// iirl_cell: one entry of the list
// Holds one entry and takes either the broadcast value or the value of a
// neighbor, depending on the command and on where it sits in the row.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_cell (
	input  wire logic                           clk,
	input  wire logic [iirl_pkg::CMP_W-1:0]     cell_index,
	input  wire iirl_pkg::cell_cmd_t            cmd,
	input  wire logic [iirl_pkg::VALUE_BITS-1:0] left_value,
	input  wire logic [iirl_pkg::VALUE_BITS-1:0] right_value,
	output logic      [iirl_pkg::VALUE_BITS-1:0] value,
	output logic      [iirl_pkg::VALUE_BITS-1:0] rd_value
);

	logic [iirl_pkg::VALUE_BITS-1:0] value_q;
	logic [iirl_pkg::VALUE_BITS-1:0] value_next;
	logic                            hit;
	logic                            above;

	assign hit   = (cell_index == cmd.pos);
	assign above = (cell_index > cmd.pos);

	always_comb begin
		value_next = value_q;
		case (cmd.op)
			iirl_pkg::CELL_INSERT: begin
				// Entries at and above the slot move up by one.
				if (hit) begin
					value_next = cmd.value;
				end else if (above) begin
					value_next = left_value;
				end
			end
			iirl_pkg::CELL_REMOVE: begin
				if (hit || above) begin
					value_next = right_value;
				end
			end
			iirl_pkg::CELL_WRITE: begin
				if (hit) begin
					value_next = cmd.value;
				end
			end
			default: begin
				value_next = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_next;
	end

	assign value    = value_q;
	assign rd_value = hit ? value_q : '0;

endmodule

`default_nettype wire

[hdl/indexed_insert_remove_list.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_list: ordered list with insert and remove at an index
// A row of cells, one per entry, shifts up or down at once; a control
// block checks each operation against the count and broadcasts the command.
// ----------------------------------------------------------------------------
//
//  channel | direction | signals
//  --------+-----------+---------------------------------------------
//  in      | to list   | in_valid, in_ready, opcode, position, item_value
//  out     | from list | out_valid, out_ready, read_value, status, entry_count
//
// For every operation the cells shift, and the result word is
// registered, at the edge that accepts the input word.
// A new input word is taken in the same cycle as the previous result word
// leaves, so the list sustains one word per cycle while out_ready is high.
// A stalled result holds in_ready low; nothing else stalls the input.
// Reset clears the count and the result valid; entries are not cleared.
//
`default_nettype none

module indexed_insert_remove_list (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [iirl_pkg::OP_W-1:0]     opcode,
	input  wire logic [iirl_pkg::POS_W-1:0]    position,
	input  wire logic [iirl_pkg::DATA_W-1:0]   item_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [iirl_pkg::DATA_W-1:0]   read_value,
	output logic      [iirl_pkg::STAT_W-1:0]   status,
	output logic      [iirl_pkg::COUNT_W-1:0]  entry_count
);

	localparam int N = iirl_pkg::CAPACITY;

	logic [iirl_pkg::CNT_W-1:0]      count_q;
	logic [iirl_pkg::CNT_W-1:0]      count_next;
	logic                            out_valid_q;
	logic [iirl_pkg::DATA_W-1:0]     read_value_q;
	logic [iirl_pkg::STAT_W-1:0]     status_q;
	logic [iirl_pkg::COUNT_W-1:0]    entry_count_q;

	logic                            accept;
	logic [iirl_pkg::CMP_W-1:0]      pos_ext;
	logic [iirl_pkg::CMP_W-1:0]      cnt_ext;
	logic [iirl_pkg::CMP_W-1:0]      count_next_ext;
	logic                            is_full;
	logic                            is_empty;
	iirl_pkg::status_t               st;
	iirl_pkg::cell_op_t              cell_op;
	logic [iirl_pkg::CMP_W-1:0]      cell_pos;
	logic                            returns_entry;
	iirl_pkg::cell_cmd_t             cmd;

	logic [iirl_pkg::VALUE_BITS-1:0] cell_value [N];
	logic [iirl_pkg::VALUE_BITS-1:0] cell_rd    [N];
	logic [iirl_pkg::VALUE_BITS-1:0] rd_bus;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign pos_ext  = iirl_pkg::CMP_W'(position);
	assign cnt_ext  = iirl_pkg::CMP_W'(count_q);
	assign is_full  = (cnt_ext == iirl_pkg::CMP_W'(N));
	assign is_empty = (count_q == '0);

	always_comb begin
		st            = iirl_pkg::ST_OK;
		cell_op       = iirl_pkg::CELL_HOLD;
		cell_pos      = pos_ext;
		returns_entry = 1'b0;
		count_next    = count_q;
		case (iirl_pkg::opcode_t'(opcode))
			iirl_pkg::OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					st = iirl_pkg::ST_RANGE;
				end else if (is_full) begin
					st = iirl_pkg::ST_FULL;
				end else begin
					cell_op    = iirl_pkg::CELL_INSERT;
					count_next = count_q + 1'b1;
				end
			end
			iirl_pkg::OP_APPEND: begin
				cell_pos = cnt_ext;
				if (is_full) begin
					st = iirl_pkg::ST_FULL;
				end else begin
					cell_op    = iirl_pkg::CELL_INSERT;
					count_next = count_q + 1'b1;
				end
			end
			iirl_pkg::OP_REMOVE: begin
				if (is_empty) begin
					st = iirl_pkg::ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					st = iirl_pkg::ST_RANGE;
				end else begin
					cell_op       = iirl_pkg::CELL_REMOVE;
					returns_entry = 1'b1;
					count_next    = count_q - 1'b1;
				end
			end
			iirl_pkg::OP_REMOVE_LAST: begin
				cell_pos = cnt_ext - 1'b1;
				if (is_empty) begin
					st = iirl_pkg::ST_EMPTY;
				end else begin
					cell_op       = iirl_pkg::CELL_REMOVE;
					returns_entry = 1'b1;
					count_next    = count_q - 1'b1;
				end
			end
			iirl_pkg::OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					st = iirl_pkg::ST_RANGE;
				end else begin
					returns_entry = 1'b1;
				end
			end
			iirl_pkg::OP_WRITE: begin
				if (pos_ext >= cnt_ext) begin
					st = iirl_pkg::ST_RANGE;
				end else begin
					cell_op = iirl_pkg::CELL_WRITE;
				end
			end
			default: begin
				st = iirl_pkg::ST_OK;
			end
		endcase
	end

	// The cells only move on the cycle a word is accepted.
	assign cmd.op    = accept ? cell_op : iirl_pkg::CELL_HOLD;
	assign cmd.pos   = cell_pos;
	assign cmd.value = iirl_pkg::to_entry(item_value);

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [iirl_pkg::VALUE_BITS-1:0] left_v;
		logic [iirl_pkg::VALUE_BITS-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = cell_value[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cell_value[i+1];
		end

		iirl_cell u_cell (
			.clk         (clk),
			.cell_index  (iirl_pkg::CMP_W'(i)),
			.cmd         (cmd),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (cell_value[i]),
			.rd_value    (cell_rd[i])
		);
	end

	// Only the addressed cell drives a nonzero value onto the read bus.
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < N; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	assign count_next_ext = iirl_pkg::CMP_W'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= returns_entry ? iirl_pkg::from_entry(rd_bus) : '0;
			status_q      <= st;
			entry_count_q <= count_next_ext[iirl_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

[hdl/iirl_checker.sv]
// ----------------------------------------------------------------------------
// iirl_checker: port-level checks of the indexed insert/remove list
// Watches the top level's ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [iirl_pkg::OP_W-1:0]     opcode,
	input wire logic [iirl_pkg::POS_W-1:0]    position,
	input wire logic [iirl_pkg::DATA_W-1:0]   item_value,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [iirl_pkg::DATA_W-1:0]   read_value,
	input wire logic [iirl_pkg::STAT_W-1:0]   status,
	input wire logic [iirl_pkg::COUNT_W-1:0]  entry_count
);

	// A stalled result word keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value)
			&& $stable(status) && $stable(entry_count))
		else $error("result word changed while stalled");

	// Every accepted word yields a result word in the next cycle.
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result word after an accepted input word");

	// The input is only blocked by a pending result word.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without a stalled result word");

	// A failed operation returns no data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != iirl_pkg::ST_OK |-> read_value == '0)
		else $error("failed operation returned data");

	// A full status is reported only when the list holds every entry.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == iirl_pkg::ST_FULL
			|-> entry_count == iirl_pkg::COUNT_W'(iirl_pkg::CAPACITY))
		else $error("full status with a list that is not full");

	// Inputs that only matter for the input channel's payload.
	logic unused_in;
	assign unused_in = ^{opcode, position, item_value};

endmodule

bind indexed_insert_remove_list iirl_checker u_iirl_checker (.*);

`default_nettype wire

[tb/indexed_insert_remove_list_tb.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_tb: self-checking bench for the ordered list
// A directed script covers the empty list, the full list, the unused opcodes
// and every error status. Random operations follow, drifting between empty
// and full. A shadow copy of the list predicts each result word the script does not give.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module indexed_insert_remove_list_tb;

	localparam logic [iirl_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [iirl_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam int RANDOM_WORDS = 520;
	localparam int CALM_WORDS   = 100;
	localparam int STALL_LIMIT  = 2000;

	typedef struct packed {
		logic [iirl_pkg::DATA_W-1:0]  value;
		iirl_pkg::status_t            stat;
		logic [iirl_pkg::COUNT_W-1:0] count;
	} list_result_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_FILL
	} row_kind_t;

	typedef struct packed {
		logic [iirl_pkg::OP_W-1:0]   op;
		logic [iirl_pkg::POS_W-1:0]  pos;
		logic [iirl_pkg::DATA_W-1:0] val;
		row_kind_t                   kind;
		list_result_t                want;
	} script_row_t;

	localparam list_result_t NO_WANT = '0;
	localparam int SCRIPT_LEN = 27;

	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		// Empty list.
		'{iirl_pkg::OP_REMOVE, 7'd0, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_EMPTY, 7'd0}},
		'{iirl_pkg::OP_REMOVE_LAST, 7'd0, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_EMPTY, 7'd0}},
		'{iirl_pkg::OP_READ, 7'd0, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd0}},
		'{iirl_pkg::OP_WRITE, 7'd0, 32'hFFFFFFFF, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd0}},
		'{iirl_pkg::OP_INSERT, 7'd1, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd0}},
		'{iirl_pkg::OP_INSERT, 7'd127, 32'hFFFFFFFF, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd0}},
		'{OP_SPARE_6, 7'd64, 32'hFFFFFFFF, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_OK, 7'd0}},
		'{OP_SPARE_7, 7'd127, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_OK, 7'd0}},
		// A few entries.
		'{iirl_pkg::OP_APPEND, 7'd0, 32'hFFFFFFFF, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_OK, 7'd1}},
		'{iirl_pkg::OP_INSERT, 7'd0, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_OK, 7'd2}},
		'{iirl_pkg::OP_INSERT, 7'd2, 32'hA5A5A5A5, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_INSERT, 7'd1, 32'h5A5A5A5A, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_READ, 7'd0, 32'h0, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_READ, 7'd4, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd4}},
		'{iirl_pkg::OP_WRITE, 7'd3, 32'h12345678, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_REMOVE, 7'd1, 32'h0, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_REMOVE, 7'd3, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd3}},
		'{iirl_pkg::OP_REMOVE_LAST, 7'd0, 32'h0, ROW_PREDICT, NO_WANT},
		// Fill up, then the full list.
		'{iirl_pkg::OP_APPEND, 7'd0, 32'h0, ROW_FILL, NO_WANT},
		'{iirl_pkg::OP_APPEND, 7'd0, 32'h1, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_FULL, 7'd64}},
		'{iirl_pkg::OP_INSERT, 7'd64, 32'h1, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_FULL, 7'd64}},
		'{iirl_pkg::OP_INSERT, 7'd65, 32'h1, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd64}},
		'{iirl_pkg::OP_READ, 7'd63, 32'h0, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_REMOVE, 7'd0, 32'h0, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_INSERT, 7'd63, 32'hFFFFFFFF, ROW_PREDICT, NO_WANT},
		'{iirl_pkg::OP_WRITE, 7'd64, 32'h0, ROW_TYPED,
			'{32'h0, iirl_pkg::ST_RANGE, 7'd64}},
		'{iirl_pkg::OP_REMOVE, 7'd63, 32'h0, ROW_PREDICT, NO_WANT}
	};

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic [iirl_pkg::OP_W-1:0]     opcode      = '0;
	logic [iirl_pkg::POS_W-1:0]    position    = '0;
	logic [iirl_pkg::DATA_W-1:0]   item_value  = '0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [iirl_pkg::DATA_W-1:0]   read_value;
	logic [iirl_pkg::STAT_W-1:0]   status;
	logic [iirl_pkg::COUNT_W-1:0]  entry_count;

	// Shadow copy of the list.
	logic [iirl_pkg::DATA_W-1:0]   list_mem [iirl_pkg::CAPACITY];
	int                            list_len = 0;

	list_result_t                  pending_results [$];
	int                            error_count = 0;
	int                            idle_cycles = 0;
	int                            rx_hold     = 0;
	bit                            tx_idle_en  = 1'b0;
	bit                            rx_stall_en = 1'b0;

	indexed_insert_remove_list uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.position    (position),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	always #1 clk = ~clk;

	// Applies one operation to the shadow list and returns the result word.
	function automatic list_result_t list_apply(input logic [iirl_pkg::OP_W-1:0] op,
			input logic [iirl_pkg::POS_W-1:0] pos,
			input logic [iirl_pkg::DATA_W-1:0] val);
		list_result_t r;
		int p;
		int i;
		r = '0;
		r.stat = iirl_pkg::ST_OK;
		case (op)
			iirl_pkg::OP_INSERT, iirl_pkg::OP_APPEND: begin
				p = (op == iirl_pkg::OP_APPEND) ? list_len : int'(pos);
				// The index check wins over the full check.
				if (p > list_len)
					r.stat = iirl_pkg::ST_RANGE;
				else if (list_len >= iirl_pkg::CAPACITY)
					r.stat = iirl_pkg::ST_FULL;
				else begin
					for (i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					list_len++;
				end
			end
			iirl_pkg::OP_REMOVE, iirl_pkg::OP_REMOVE_LAST: begin
				p = (op == iirl_pkg::OP_REMOVE_LAST) ? list_len - 1 : int'(pos);
				if (list_len == 0)
					r.stat = iirl_pkg::ST_EMPTY;
				else if (p >= list_len)
					r.stat = iirl_pkg::ST_RANGE;
				else begin
					r.value = list_mem[p];
					for (i = p; i < list_len - 1; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			iirl_pkg::OP_READ: begin
				if (int'(pos) >= list_len)
					r.stat = iirl_pkg::ST_RANGE;
				else
					r.value = list_mem[pos];
			end
			iirl_pkg::OP_WRITE: begin
				if (int'(pos) >= list_len)
					r.stat = iirl_pkg::ST_RANGE;
				else
					list_mem[pos] = val;
			end
			default: begin
			end
		endcase
		r.count = iirl_pkg::COUNT_W'(list_len);
		return r;
	endfunction

	function automatic logic [iirl_pkg::DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what,
			input logic [iirl_pkg::DATA_W-1:0] got,
			input logic [iirl_pkg::DATA_W-1:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Presents one word, holds it until accepted, and queues its expected result.
	task automatic send_word(input logic [iirl_pkg::OP_W-1:0] op,
			input logic [iirl_pkg::POS_W-1:0] pos,
			input logic [iirl_pkg::DATA_W-1:0] val, input bit typed,
			input list_result_t want);
		list_result_t predicted;
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		position   <= pos;
		item_value <= val;
		do @(posedge clk); while (!in_ready);
		predicted = list_apply(op, pos, val);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic drain_pause();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Result side: random stall bursts while enabled.
	always @(posedge clk) begin
		if (rx_hold == 0 && rx_stall_en && $urandom_range(0, 5) == 0)
			rx_hold = $urandom_range(1, 9);
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0)
				report_mismatch("result word with nothing pending", read_value, '0);
			else begin
				want = pending_results.pop_front();
				if (read_value !== want.value)
					report_mismatch("read_value", read_value, want.value);
				if (status !== want.stat)
					report_mismatch("status", iirl_pkg::DATA_W'(status),
						iirl_pkg::DATA_W'(want.stat));
				if (entry_count !== want.count)
					report_mismatch("entry_count", iirl_pkg::DATA_W'(entry_count),
						iirl_pkg::DATA_W'(want.count));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int i;
		int r;
		bit growing;
		logic [iirl_pkg::OP_W-1:0] op;
		logic [iirl_pkg::POS_W-1:0] pos;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_en  = 1'b1;
		rx_stall_en = 1'b1;

		for (i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].kind == ROW_FILL) begin
				while (list_len < iirl_pkg::CAPACITY) begin
					op = $urandom_range(0, 1) ? iirl_pkg::OP_APPEND : iirl_pkg::OP_INSERT;
					send_word(op, iirl_pkg::POS_W'($urandom_range(0, list_len)),
						pick_value(), 1'b0, NO_WANT);
				end
			end else
				send_word(SCRIPT[i].op, SCRIPT[i].pos, SCRIPT[i].val,
					SCRIPT[i].kind == ROW_TYPED, SCRIPT[i].want);
		end
		drain_pause();

		// Random part: the list drifts toward full, then toward empty, and so on.
		growing = 1'b1;
		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i >= RANDOM_WORDS - CALM_WORDS) begin
				tx_idle_en  = 1'b0;
				rx_stall_en = 1'b0;
			end else if (i % 40 == 0) begin
				tx_idle_en  = $urandom_range(0, 2) != 0;
				rx_stall_en = $urandom_range(0, 2) != 0;
			end
			if (i == RANDOM_WORDS / 2)
				drain_pause();
			if (list_len == iirl_pkg::CAPACITY)
				growing = 1'b0;
			else if (list_len == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				growing = !growing;

			r = $urandom_range(0, 99);
			if (r < 4) begin
				op  = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
				pos = iirl_pkg::POS_W'($urandom_range(0, 127));
			end else if (r < 12) begin
				op  = iirl_pkg::OP_W'($urandom_range(iirl_pkg::OP_INSERT,
					iirl_pkg::OP_WRITE));
				pos = iirl_pkg::POS_W'($urandom_range(0, 127));
			end else begin
				r = $urandom_range(0, 99);
				if (growing)
					op = (r < 35) ? iirl_pkg::OP_INSERT : (r < 60) ? iirl_pkg::OP_APPEND :
						(r < 70) ? iirl_pkg::OP_REMOVE : (r < 75) ? iirl_pkg::OP_REMOVE_LAST :
						(r < 87) ? iirl_pkg::OP_READ : iirl_pkg::OP_WRITE;
				else
					op = (r < 10) ? iirl_pkg::OP_INSERT : (r < 15) ? iirl_pkg::OP_APPEND :
						(r < 45) ? iirl_pkg::OP_REMOVE : (r < 65) ? iirl_pkg::OP_REMOVE_LAST :
						(r < 82) ? iirl_pkg::OP_READ : iirl_pkg::OP_WRITE;
				if (op == iirl_pkg::OP_INSERT)
					pos = iirl_pkg::POS_W'($urandom_range(0, list_len));
				else
					pos = (list_len == 0) ? '0 :
						iirl_pkg::POS_W'($urandom_range(0, list_len - 1));
			end
			send_word(op, pos, pick_value(), 1'b0, NO_WANT);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
hdl/iirl_pkg.sv
hdl/iirl_cell.sv
hdl/indexed_insert_remove_list.sv
hdl/iirl_checker.sv
tb/indexed_insert_remove_list_tb.sv
